// File: rtl/core/rlmdc_pkg.sv
// shared types, sizes and codes for the resource lock manager
package rlmdc_pkg;

   // sizing
   localparam int NUM_PROCESSES = 16;
   localparam int NUM_RESOURCES = 16;
   localparam int PROC_W = $clog2(NUM_PROCESSES);
   localparam int RES_W  = $clog2(NUM_RESOURCES);
   localparam int LEN_W  = $clog2(NUM_PROCESSES + 1);
   localparam int CNT_W  = $clog2(NUM_RESOURCES + 1);
   localparam int ADDR_W = RES_W + PROC_W;

   // operation kinds
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_CHECK   = 2'd2;

   // response codes
   localparam logic [2:0] RSP_AVAIL = 3'd0;
   localparam logic [2:0] RSP_WAIT  = 3'd1;
   localparam logic [2:0] RSP_TERM  = 3'd2;
   localparam logic [2:0] RSP_KILL  = 3'd3;
   localparam logic [2:0] RSP_NONE  = 3'd4;

   // request transaction
   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] process_id;
      logic [3:0] resource_id;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [2:0] response;
      logic [5:0] count_first;
      logic [4:0] count_second;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;
      logic       res_item;
      logic       res_clear;
      logic       res_next;
      logic       pos_clear;
      logic       pos_next;
      logic       read_pos;
      logic       read_next;
      logic       write_pos;
      logic       append;
      logic       len_dec;
      logic       hold_pid;
      logic       hold_data;
      logic       hold_free;
      logic       waits_inc;
      logic       held_inc;
      logic       seen_set;
      logic       adj_clear;
      logic       adj_mark;
      logic       alive_init;
      logic       alive_step;
      logic       emit;
      logic [2:0] code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic       item_ok;
      logic       res_ok;
      logic       seen;
      logic       pos_at_len;
      logic       pos1_at_len;
      logic       match;
      logic       holder_valid;
      logic       holder_is_pid;
      logic       len_full;
      logic       len_zero;
      logic       res_last;
      logic       iter_last;
      logic       alive_p;
      logic       out_free;
   } status_type;

endpackage

// File: rtl/core/rlmdc_datapath.sv
// lock tables, wait queue memory, wait-for graph and response register
module rlmdc_datapath import rlmdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   req_type             item_ff, item_in;
   logic [RES_W-1:0]    res_ff, res_in;
   logic [LEN_W-1:0]    pos_ff, pos_in;
   logic [PROC_W-1:0]   iter_ff, iter_in;
   logic [PROC_W-1:0]   rd_data_ff;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [CNT_W-1:0]    waits_ff, waits_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [NUM_PROCESSES-1:0] alive_ff, alive_in;
   logic [NUM_PROCESSES-1:0] seen_ff;

   logic [LEN_W-1:0]    len_ff [NUM_RESOURCES];
   logic [NUM_RESOURCES-1:0] holder_valid_ff;
   logic [PROC_W-1:0]   holder_id_ff [NUM_RESOURCES];
   logic [NUM_PROCESSES-1:0] adj_ff [NUM_PROCESSES];
   logic [PROC_W-1:0]   queue_mem [2**ADDR_W];

   logic [PROC_W-1:0]   pid;
   logic [LEN_W-1:0]    len_cur;
   logic [LEN_W-1:0]    rd_pos;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic [PROC_W-1:0]   wr_data;

   assign pid     = PROC_W'(item_ff.process_id);
   assign len_cur = len_ff[res_ff];

   // status toward the controller
   always_comb begin
      status.kind          = item_ff.kind;
      status.item_ok       = int'(item_ff.process_id) < NUM_PROCESSES;
      status.res_ok        = int'(item_ff.resource_id) < NUM_RESOURCES;
      status.seen          = seen_ff[pid];
      status.pos_at_len    = pos_ff >= len_cur;
      status.pos1_at_len   = ({1'b0, pos_ff} + (LEN_W+1)'(1)) >= {1'b0, len_cur};
      status.match         = rd_data_ff == pid;
      status.holder_valid  = holder_valid_ff[res_ff];
      status.holder_is_pid = holder_id_ff[res_ff] == pid;
      status.len_full      = len_cur == LEN_W'(NUM_PROCESSES);
      status.len_zero      = len_cur == '0;
      status.res_last      = res_ff == RES_W'(NUM_RESOURCES - 1);
      status.iter_last     = iter_ff == PROC_W'(NUM_PROCESSES - 1);
      status.alive_p       = alive_ff[pid];
      status.out_free      = !rsp_valid_ff || !rsp_stall;
   end

   // queue memory addressing
   always_comb begin
      rd_pos  = cmd.read_next ? pos_ff + LEN_W'(1) : pos_ff;
      rd_addr = {res_ff, rd_pos[PROC_W-1:0]};
      wr_addr = cmd.append ? {res_ff, len_cur[PROC_W-1:0]} : {res_ff, pos_ff[PROC_W-1:0]};
      wr_data = cmd.append ? pid : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.read_pos || cmd.read_next) begin
         rd_data_ff <= queue_mem[rd_addr];
      end
      if (cmd.write_pos || cmd.append) begin
         queue_mem[wr_addr] <= wr_data;
      end
   end

   // counters and item capture
   always_comb begin
      item_in  = cmd.accept ? req_data : item_ff;
      res_in   = res_ff;
      held_in  = held_ff;
      waits_in = waits_ff;
      pos_in   = pos_ff;
      iter_in  = iter_ff;
      if (cmd.res_item) begin
         res_in = RES_W'(item_ff.resource_id);
      end else if (cmd.res_clear) begin
         res_in   = '0;
         held_in  = '0;
         waits_in = '0;
      end else if (cmd.res_next) begin
         res_in = res_ff + RES_W'(1);
      end
      if (cmd.held_inc) begin
         held_in = held_ff + CNT_W'(1);
      end
      if (cmd.waits_inc) begin
         waits_in = waits_ff + CNT_W'(1);
      end
      if (cmd.pos_clear) begin
         pos_in = '0;
      end else if (cmd.pos_next) begin
         pos_in = pos_ff + LEN_W'(1);
      end
      if (cmd.alive_init) begin
         iter_in = '0;
      end else if (cmd.alive_step) begin
         iter_in = iter_ff + PROC_W'(1);
      end
   end

   // prune processes with no live successor
   always_comb begin
      alive_in = alive_ff;
      if (cmd.alive_init) begin
         alive_in = '1;
      end else if (cmd.alive_step) begin
         for (int q = 0; q < NUM_PROCESSES; q++) begin
            alive_in[q] = alive_ff[q] & (|(adj_ff[q] & alive_ff));
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.response      = cmd.code;
         rsp_data_in.count_first   = '0;
         rsp_data_in.count_second  = '0;
         case (cmd.code)
            RSP_WAIT: rsp_data_in.count_first = 6'(len_cur);
            RSP_TERM: rsp_data_in.count_first = 6'(held_ff) + 6'(waits_ff);
            RSP_KILL: begin
               rsp_data_in.count_first  = 6'(held_ff);
               rsp_data_in.count_second = 5'(waits_ff);
            end
            default: rsp_data_in.count_first = '0;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // payload and working registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      pos_ff      <= pos_in;
      iter_ff     <= iter_in;
      held_ff     <= held_in;
      waits_ff    <= waits_in;
      alive_ff    <= alive_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.adj_clear) begin
         for (int q = 0; q < NUM_PROCESSES; q++) begin
            adj_ff[q] <= '0;
         end
      end else if (cmd.adj_mark) begin
         adj_ff[rd_data_ff][holder_id_ff[res_ff]] <= 1'b1;
      end
      if (cmd.hold_pid) begin
         holder_id_ff[res_ff] <= pid;
      end else if (cmd.hold_data) begin
         holder_id_ff[res_ff] <= rd_data_ff;
      end
   end

   // lock table control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         seen_ff         <= '0;
         holder_valid_ff <= '0;
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            len_ff[r] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.seen_set) begin
            seen_ff[pid] <= 1'b1;
         end
         if (cmd.hold_pid || cmd.hold_data) begin
            holder_valid_ff[res_ff] <= 1'b1;
         end else if (cmd.hold_free) begin
            holder_valid_ff[res_ff] <= 1'b0;
         end
         if (cmd.append) begin
            len_ff[res_ff] <= len_cur + LEN_W'(1);
         end else if (cmd.len_dec) begin
            len_ff[res_ff] <= len_cur - LEN_W'(1);
         end
      end
   end

endmodule

// File: rtl/core/rlmdc_ctrl.sv
// sequencer for request, free and deadlock check operations
module rlmdc_ctrl import rlmdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_F_RD, S_F_CHK, S_Q_AFTER, S_Q_TAKE,
      S_DROP_RD, S_DROP_WR, S_REL_START, S_R_FIND, S_R_AFTER, S_R_HAND,
      S_R_HRD, S_R_HWR, S_R_NEXT, S_B_START, S_B_RD, S_B_MARK, S_ITER,
      S_DECIDE, S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   logic       found_ff, found_in;
   logic       mode_rel_ff, mode_rel_in;
   logic [2:0] code_ff, code_in;

   assign req_stall = state_ff != S_IDLE;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      found_in    = found_ff;
      mode_rel_in = mode_rel_ff;
      code_in     = code_ff;
      cmd         = '0;
      cmd.code    = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!status.item_ok) begin
               state_in = S_IDLE;
            end else begin
               case (status.kind)
                  KIND_REQUEST: begin
                     if (status.res_ok) begin
                        cmd.res_item  = 1'b1;
                        cmd.pos_clear = 1'b1;
                        cmd.seen_set  = 1'b1;
                        found_in      = 1'b0;
                        mode_rel_in   = 1'b0;
                        state_in      = S_F_RD;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
                  KIND_FREE: begin
                     if (status.seen) begin
                        code_in     = RSP_TERM;
                        mode_rel_in = 1'b1;
                        state_in    = S_REL_START;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
                  KIND_CHECK: begin
                     if (status.seen) begin
                        state_in = S_B_START;
                     end else begin
                        code_in  = RSP_NONE;
                        state_in = S_EMIT;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         // search the queue of the current resource for the process
         S_F_RD: begin
            if (status.pos_at_len) begin
               state_in = mode_rel_ff ? S_R_AFTER : S_Q_AFTER;
            end else begin
               cmd.read_pos = 1'b1;
               state_in     = S_F_CHK;
            end
         end
         S_F_CHK: begin
            if (status.match) begin
               found_in = 1'b1;
               state_in = mode_rel_ff ? S_R_AFTER : S_Q_AFTER;
            end else begin
               cmd.pos_next = 1'b1;
               state_in     = S_F_RD;
            end
         end
         // request outcome
         S_Q_AFTER: begin
            if (!status.holder_valid) begin
               if (found_ff) begin
                  ret_in   = S_Q_TAKE;
                  state_in = S_DROP_RD;
               end else begin
                  state_in = S_Q_TAKE;
               end
            end else begin
               if (!found_ff && !status.len_full) begin
                  cmd.append = 1'b1;
               end
               code_in  = RSP_WAIT;
               state_in = S_EMIT;
            end
         end
         S_Q_TAKE: begin
            cmd.hold_pid = 1'b1;
            code_in      = RSP_AVAIL;
            state_in     = S_EMIT;
         end
         // remove the entry at the current position, closing the gap
         S_DROP_RD: begin
            if (status.pos1_at_len) begin
               cmd.len_dec = 1'b1;
               state_in    = ret_ff;
            end else begin
               cmd.read_next = 1'b1;
               state_in      = S_DROP_WR;
            end
         end
         S_DROP_WR: begin
            cmd.write_pos = 1'b1;
            cmd.pos_next  = 1'b1;
            state_in      = S_DROP_RD;
         end
         // release every wait and lock of the process
         S_REL_START: begin
            cmd.res_clear = 1'b1;
            state_in      = S_R_FIND;
         end
         S_R_FIND: begin
            cmd.pos_clear = 1'b1;
            found_in      = 1'b0;
            state_in      = S_F_RD;
         end
         S_R_AFTER: begin
            if (found_ff) begin
               cmd.waits_inc = 1'b1;
               ret_in        = S_R_HAND;
               state_in      = S_DROP_RD;
            end else begin
               state_in = S_R_HAND;
            end
         end
         S_R_HAND: begin
            if (status.holder_valid && status.holder_is_pid) begin
               cmd.held_inc = 1'b1;
               if (status.len_zero) begin
                  cmd.hold_free = 1'b1;
                  state_in      = S_R_NEXT;
               end else begin
                  cmd.pos_clear = 1'b1;
                  state_in      = S_R_HRD;
               end
            end else begin
               state_in = S_R_NEXT;
            end
         end
         S_R_HRD: begin
            cmd.read_pos = 1'b1;
            state_in     = S_R_HWR;
         end
         S_R_HWR: begin
            cmd.hold_data = 1'b1;
            ret_in        = S_R_NEXT;
            state_in      = S_DROP_RD;
         end
         S_R_NEXT: begin
            if (status.res_last) begin
               state_in = S_EMIT;
            end else begin
               cmd.res_next = 1'b1;
               state_in     = S_R_FIND;
            end
         end
         // build the process wait-for matrix
         S_B_START: begin
            cmd.res_clear = 1'b1;
            cmd.adj_clear = 1'b1;
            cmd.pos_clear = 1'b1;
            state_in      = S_B_RD;
         end
         S_B_RD: begin
            if (status.pos_at_len) begin
               if (status.res_last) begin
                  cmd.alive_init = 1'b1;
                  state_in       = S_ITER;
               end else begin
                  cmd.res_next  = 1'b1;
                  cmd.pos_clear = 1'b1;
               end
            end else begin
               cmd.read_pos = 1'b1;
               state_in     = S_B_MARK;
            end
         end
         S_B_MARK: begin
            cmd.adj_mark = status.holder_valid;
            cmd.pos_next = 1'b1;
            state_in     = S_B_RD;
         end
         // prune until only processes that reach a cycle remain
         S_ITER: begin
            cmd.alive_step = 1'b1;
            if (status.iter_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.alive_p) begin
               code_in     = RSP_KILL;
               mode_rel_in = 1'b1;
               state_in    = S_REL_START;
            end else begin
               code_in  = RSP_NONE;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered controls
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_ff      <= S_IDLE;
         found_ff    <= 1'b0;
         mode_rel_ff <= 1'b0;
         code_ff     <= RSP_NONE;
      end else begin
         state_ff    <= state_in;
         ret_ff      <= ret_in;
         found_ff    <= found_in;
         mode_rel_ff <= mode_rel_in;
         code_ff     <= code_in;
      end
   end

endmodule

// File: rtl/core/resource_lock_manager_deadlock_check_top.sv
// top level of the resource lock manager with deadlock check
// Takes one command transaction at a time: request a resource, free a process, or check a
// process for deadlock. Each resource has one holder and a FIFO wait queue kept in a
// single-port memory; every queue step is a registered read, then its use. A free scans
// every resource queue. A check first scans all queues to build the wait-for matrix, then
// prunes it; on a deadlock it runs the same release as a free.
// The response register lets a new command be taken while a response is still stalled.
module resource_lock_manager_deadlock_check_top import rlmdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   rlmdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // tables, queues and response register
   rlmdc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/resource_lock_manager_deadlock_check_top_tb.sv
// testbench for the resource lock manager with deadlock check: directed, random and back-pressure
module resource_lock_manager_deadlock_check_top_tb;
   import rlmdc_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int SETTLE_WAIT  = 1500;
   localparam int NODES        = NUM_PROCESSES + NUM_RESOURCES;
   localparam int EXPECT_DEPTH = 1024;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the lock tables
   bit          proc_seen       [NUM_PROCESSES];
   bit          owner_valid     [NUM_RESOURCES];
   int unsigned owner_id        [NUM_RESOURCES];
   int unsigned wait_line       [NUM_RESOURCES][NUM_PROCESSES];
   int unsigned wait_len        [NUM_RESOURCES];

   // expected transactions in order of acceptance
   rsp_type     expect_mem [EXPECT_DEPTH];
   int          expect_wr = 0;
   int          expect_rd = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          long_hold_asks = 0;
   int          stall_percent = 0;

   resource_lock_manager_deadlock_check_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stall: random mix, quiet stretches, and long hold-offs on request
   always @(posedge clock) begin : stall_gen
      int hold_left;
      int phase_left;
      int asks_served;
      if (reset) begin
         hold_left = 0;
         phase_left = 0;
         asks_served = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (asks_served != long_hold_asks) begin
            asks_served = long_hold_asks;
            hold_left = 2000;
         end
         if (phase_left == 0) begin
            phase_left = $urandom_range(50, 300);
            case ($urandom_range(0, 4))
               0, 1: stall_percent = 0;
               2: stall_percent = 30;
               3: stall_percent = 60;
               default: begin
                  stall_percent = 0;
                  hold_left = $urandom_range(30, 120);
               end
            endcase
         end
         phase_left = phase_left - 1;
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_percent);
         end
      end
   end

   // wait queue helpers
   function automatic int find_waiter(int unsigned r, int unsigned p);
      for (int i = 0; i < wait_len[r]; i++)
         if (wait_line[r][i] == p) return i;
      return -1;
   endfunction

   function automatic void drop_waiter(int unsigned r, int unsigned pos);
      for (int unsigned i = pos; i + 1 < wait_len[r]; i++)
         wait_line[r][i] = wait_line[r][i + 1];
      if (wait_len[r] > 0) wait_len[r]--;
   endfunction

   // drop all waits of p, hand its resources to queue heads
   function automatic void release_process(int unsigned p, output int unsigned held,
                                           output int unsigned waits);
      int pos;
      held = 0;
      waits = 0;
      for (int unsigned r = 0; r < NUM_RESOURCES; r++) begin
         pos = find_waiter(r, p);
         if (pos >= 0) begin
            drop_waiter(r, pos);
            waits++;
         end
      end
      for (int unsigned r = 0; r < NUM_RESOURCES; r++) begin
         if (owner_valid[r] && owner_id[r] == p) begin
            held++;
            if (wait_len[r] > 0) begin
               owner_id[r] = wait_line[r][0];
               drop_waiter(r, 0);
            end else begin
               owner_valid[r] = 1'b0;
            end
         end
      end
   endfunction

   // depth-first walk of the wait-for graph, true when a cycle is reachable
   function automatic bit deadlock_reachable(int unsigned p);
      int unsigned stk[NODES];
      int unsigned cur[NODES];
      int unsigned color[NODES];
      int unsigned sp, n, v, r;
      bit found;
      for (int i = 0; i < NODES; i++) color[i] = 0;
      stk[0] = p;
      cur[0] = 0;
      color[p] = 1;
      sp = 1;
      while (sp > 0) begin
         n = stk[sp - 1];
         found = 1'b0;
         v = 0;
         if (n < NUM_PROCESSES) begin
            while (cur[sp - 1] < NUM_RESOURCES && !found) begin
               r = cur[sp - 1];
               cur[sp - 1]++;
               if (find_waiter(r, n) >= 0) begin
                  v = NUM_PROCESSES + r;
                  found = 1'b1;
               end
            end
         end else if (cur[sp - 1] == 0) begin
            cur[sp - 1] = 1;
            r = n - NUM_PROCESSES;
            if (owner_valid[r]) begin
               v = owner_id[r];
               found = 1'b1;
            end
         end
         if (!found) begin
            color[n] = 2;
            sp--;
         end else if (color[v] == 1) begin
            return 1'b1;
         end else if (color[v] == 0 && sp < NODES) begin
            color[v] = 1;
            stk[sp] = v;
            cur[sp] = 0;
            sp++;
         end
      end
      return 1'b0;
   endfunction

   // expected response of one command, updates the shadow tables
   function automatic void predict_lock_response(req_type d, output bit has_rsp,
                                                 output rsp_type rsp);
      int unsigned p, r, held, waits;
      int pos;
      p = d.process_id;
      r = d.resource_id;
      has_rsp = 1'b1;
      rsp = '0;
      case (d.kind)
         KIND_REQUEST: begin
            proc_seen[p] = 1'b1;
            if (!owner_valid[r]) begin
               pos = find_waiter(r, p);
               if (pos >= 0) drop_waiter(r, pos);
               owner_valid[r] = 1'b1;
               owner_id[r] = p;
               rsp.response = RSP_AVAIL;
            end else begin
               if (find_waiter(r, p) < 0 && wait_len[r] < NUM_PROCESSES) begin
                  wait_line[r][wait_len[r]] = p;
                  wait_len[r]++;
               end
               rsp.response = RSP_WAIT;
               rsp.count_first = 6'(wait_len[r]);
            end
         end
         KIND_FREE: begin
            if (!proc_seen[p]) begin
               has_rsp = 1'b0;
            end else begin
               release_process(p, held, waits);
               rsp.response = RSP_TERM;
               rsp.count_first = 6'(held + waits);
            end
         end
         KIND_CHECK: begin
            if (proc_seen[p] && deadlock_reachable(p)) begin
               release_process(p, held, waits);
               rsp.response = RSP_KILL;
               rsp.count_first = 6'(held);
               rsp.count_second = 5'(waits);
            end else begin
               rsp.response = RSP_NONE;
            end
         end
         default: has_rsp = 1'b0;
      endcase
   endfunction

   // offer one command, record its expected response when taken, then idle if a gap is given
   task automatic send_command(logic [1:0] kind, int unsigned pid, int unsigned rid, int gap);
      req_type d;
      bit has_rsp;
      rsp_type rsp;
      d.kind = kind;
      d.process_id = 4'(pid);
      d.resource_id = 4'(rid);
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_lock_response(d, has_rsp, rsp);
      if (has_rsp) begin
         expect_mem[expect_wr[9:0]] = rsp;
         expect_wr++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mostly short gaps, a few long ones, sometimes none at all
   function automatic int pick_gap(bit busy);
      if (busy) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(20, 80);
   endfunction

   // stop offering, wait for every expected transaction, then let the block settle
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expect_wr != expect_rd) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // response checking
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expect_wr == expect_rd) begin
            $error("unexpected transaction response=%0d", rsp_data.response);
            error_count++;
         end else begin
            want = expect_mem[expect_rd[9:0]];
            expect_rd++;
            if (rsp_data.response !== want.response) begin
               $error("response expected %0d actual %0d", want.response, rsp_data.response);
               error_count++;
            end
            if (rsp_data.count_first !== want.count_first) begin
               $error("count_first expected %0d actual %0d", want.count_first,
                      rsp_data.count_first);
               error_count++;
            end
            if (rsp_data.count_second !== want.count_second) begin
               $error("count_second expected %0d actual %0d", want.count_second,
                      rsp_data.count_second);
               error_count++;
            end
         end
      end
   end

   // directed: each response kind, the special cases and field extremes
   task automatic test_directed();
      send_command(KIND_CHECK, 9, 0, 1);      // check of an unseen process
      send_command(KIND_FREE, 10, 15, 1);     // free of an unseen process
      send_command(KIND_IGNORED, 15, 15, 1);  // reserved kind
      send_command(KIND_REQUEST, 0, 0, 0);    // avail
      send_command(KIND_REQUEST, 1, 0, 0);    // wait, length 1
      send_command(KIND_REQUEST, 1, 0, 0);    // duplicate wait
      send_command(KIND_REQUEST, 0, 0, 0);    // holder queues on its own resource
      send_command(KIND_REQUEST, 1, 1, 0);
      send_command(KIND_REQUEST, 0, 1, 0);    // closes a cycle
      send_command(KIND_CHECK, 2, 0, 0);      // seen? no: none
      send_command(KIND_CHECK, 0, 0, 0);      // kill
      send_command(KIND_CHECK, 1, 0, 0);
      send_command(KIND_FREE, 1, 0, 0);       // term
      send_command(KIND_REQUEST, 15, 15, 0);
      send_command(KIND_REQUEST, 14, 15, 0);
      send_command(KIND_REQUEST, 13, 15, 0);
      send_command(KIND_CHECK, 14, 0, 0);
      send_command(KIND_FREE, 15, 0, 0);      // hand off to head of queue
      send_command(KIND_FREE, 14, 0, 0);
      send_command(KIND_FREE, 13, 0, 0);
      send_command(KIND_FREE, 0, 0, 2);
      drain_all();
   endtask

   // random commands, mostly within a small pool so locks contend and cycles form
   task automatic test_random_traffic(int count, bit busy);
      int unsigned pbase, rbase, pspan, rspan, pid, rid, sel;
      logic [1:0] kind;
      pbase = $urandom_range(0, 12);
      rbase = $urandom_range(0, 12);
      pspan = $urandom_range(1, 3);
      rspan = $urandom_range(1, 3);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 49) begin
            pbase = $urandom_range(0, 12);
            rbase = $urandom_range(0, 12);
         end
         sel = $urandom_range(0, 99);
         if (sel < 55) kind = KIND_REQUEST;
         else if (sel < 72) kind = KIND_FREE;
         else if (sel < 95) kind = KIND_CHECK;
         else kind = KIND_IGNORED;
         if ($urandom_range(0, 9) == 0) begin
            pid = $urandom_range(0, 15);
            rid = $urandom_range(0, 15);
         end else begin
            pid = pbase + $urandom_range(0, pspan);
            rid = rbase + $urandom_range(0, rspan);
         end
         send_command(kind, pid, rid, pick_gap(busy));
      end
      drain_all();
   endtask

   // long receiver hold-off while commands keep coming
   task automatic test_backpressure();
      long_hold_asks = long_hold_asks + 1;
      test_random_traffic(60, 1'b1);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(180, 1'b0);
      test_backpressure();
      test_random_traffic(80, 1'b1);
      test_random_traffic(60, 1'b0);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: resource_lock_manager_deadlock_check_top.f
rtl/core/rlmdc_pkg.sv
rtl/core/rlmdc_datapath.sv
rtl/core/rlmdc_ctrl.sv
rtl/core/resource_lock_manager_deadlock_check_top.sv
tb/resource_lock_manager_deadlock_check_top_tb.sv
